@@ rtl/lpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_pkg: loop player crossfade shared definitions
// Widths, register map, item codes and the equal-power gain table.
// ----------------------------------------------------------------------------
package lpc_pkg;

	localparam int ADDR_BITS       = 15;
	localparam int FADE_LENGTH     = 256;
	localparam int DATA_BITS       = 32;
	localparam int LOOP_START_BITS = 15;
	localparam int LOOP_END_BITS   = 16;
	localparam int GAIN_BITS       = 17;
	localparam int GAIN_FRAC_BITS  = 15;
	localparam int MEM_DEPTH       = 1 << ADDR_BITS;

	localparam int FADE_BITS     = (FADE_LENGTH > 1) ? $clog2(FADE_LENGTH) : 1;
	localparam int GAIN_IDX_BITS = $clog2(FADE_LENGTH + 1);

	localparam int WIDE_ADDR_BITS = (ADDR_BITS > LOOP_END_BITS) ? ADDR_BITS : LOOP_END_BITS;
	localparam int DIFF_BITS      = WIDE_ADDR_BITS + 2;
	localparam int CMP_BITS       = ((ADDR_BITS + 1) > LOOP_END_BITS) ? (ADDR_BITS + 1)
		: LOOP_END_BITS;
	localparam int SUM_BITS       = ((ADDR_BITS > LOOP_START_BITS) ? ADDR_BITS
		: LOOP_START_BITS) + 2 + ((FADE_BITS > LOOP_START_BITS) ? FADE_BITS : 0);

	localparam int PROD_BITS = DATA_BITS + GAIN_BITS + 1;
	localparam int MIX_BITS  = PROD_BITS + 1;
	localparam int SHR_BITS  = MIX_BITS - GAIN_FRAC_BITS;

	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam logic [LOOP_START_BITS-1:0] LOOP_START_RESET = LOOP_START_BITS'(12030);
	localparam logic [LOOP_END_BITS-1:0]   LOOP_END_RESET   = LOOP_END_BITS'(24098);

	// register index, taken from paddr[2]
	localparam logic REG_LOOP_START = 1'b0;
	localparam logic REG_LOOP_END   = 1'b1;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_PLAY = 1'b1;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(32768);

	typedef logic [GAIN_BITS-1:0] gain_t;
	typedef gain_t gain_tab_t [0:FADE_LENGTH];

	// shift-subtract quotient, used only while building the table
	function automatic longint unsigned div_u64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// sin(k/FADE_LENGTH * pi/2) in Q1.15, Taylor series through x^13 in Q2.30
	function automatic gain_t quarter_sine(input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint unsigned q;
		longint unsigned dv;
		longint          acc;
		x    = div_u64(longint'(k) * HALF_PI_Q30, 64'(FADE_LENGTH));
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			dv   = longint'(4 * n * n + 2 * n);
			term = (term * x) >> 30;
			term = div_u64((term * x) >> 30, dv);
			if ((n & 1) == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		q = (longint'(acc) + 64'd16384) >> 15;
		if (q > 64'd32768) begin
			q = 64'd32768;
		end
		return q[GAIN_BITS-1:0];
	endfunction

	function automatic gain_tab_t build_gain_rom();
		gain_tab_t tab;
		for (int k = 0; k <= FADE_LENGTH; k++) begin
			tab[k] = quarter_sine(k);
		end
		return tab;
	endfunction

	localparam gain_tab_t GAIN_ROM = build_gain_rom();

endpackage
`default_nettype wire

@@ rtl/lpc_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lpc_ram: generic sample store
// One write port and two read ports sharing a read enable, registered read.
// ----------------------------------------------------------------------------
module lpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

@@ rtl/loop_player_crossfade_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// loop_player_crossfade_unit: looping sample player with seam crossfade
// Load items fill the sample store; play items return one sample each.
// ----------------------------------------------------------------------------
// A load transfer writes one sample into the store and returns nothing. The
// result of a play transfer passes the store read and gains, the products,
// the mix and then the output register; one transfer of either kind is taken
// every cycle while the output side keeps up, and up to four play results are
// held while out_stall is high. The sample store is read at the play position
// and at the loop head in the same cycle the play transfer is taken, and a
// load is visible to a play accepted on the very next cycle. Store entries are
// undefined until loaded; there is no clearing pass. The loop start and end
// registers should be written only while idle.
// ----------------------------------------------------------------------------
module loop_player_crossfade_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   psel,
	input  wire logic                                   penable,
	input  wire logic                                   pwrite,
	input  wire logic [lpc_pkg::PADDR_BITS-1:0]         paddr,
	input  wire logic [lpc_pkg::PDATA_BITS-1:0]         pwdata,
	output logic      [lpc_pkg::PDATA_BITS-1:0]         prdata,
	output logic                                        pready,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   mode,
	input  wire logic [lpc_pkg::ADDR_BITS-1:0]          load_address,
	input  wire logic signed [lpc_pkg::DATA_BITS-1:0]   load_value,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [lpc_pkg::DATA_BITS-1:0]        out_sample,
	output logic                                        in_crossfade
);

	logic [lpc_pkg::LOOP_START_BITS-1:0] start_addr_q;
	logic [lpc_pkg::LOOP_END_BITS-1:0]   end_addr_q;
	logic [lpc_pkg::ADDR_BITS-1:0]       pos_q;

	logic cfg_wr;
	logic in_acc;
	logic play_acc;
	logic load_acc;

	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic out_free, s3_free, s2_free, s1_free;
	logic adv_s1, adv_s2, adv_s3;

	logic [lpc_pkg::DIFF_BITS-1:0]     fade_off;
	logic                              in_fade;
	logic [lpc_pkg::FADE_BITS-1:0]     fade_idx;
	logic [lpc_pkg::ADDR_BITS-1:0]     head_addr;
	logic [lpc_pkg::ADDR_BITS:0]       pos_inc;
	logic                              pos_wrap;
	logic [lpc_pkg::ADDR_BITS-1:0]     pos_jump;
	logic [lpc_pkg::ADDR_BITS-1:0]     pos_next;
	lpc_pkg::gain_t                    cos_gain;
	lpc_pkg::gain_t                    sin_gain;

	logic [lpc_pkg::DATA_BITS-1:0] ram_a;
	logic [lpc_pkg::DATA_BITS-1:0] ram_b;

	logic           fade_s1;
	lpc_pkg::gain_t cos_s1;
	lpc_pkg::gain_t sin_s1;

	logic signed [lpc_pkg::DATA_BITS-1:0]   samp_a;
	logic signed [lpc_pkg::DATA_BITS-1:0]   samp_b;
	logic signed [lpc_pkg::GAIN_BITS:0]     cos_sg;
	logic signed [lpc_pkg::GAIN_BITS:0]     sin_sg;
	logic signed [lpc_pkg::PROD_BITS-1:0]   mul_a;
	logic signed [lpc_pkg::PROD_BITS-1:0]   mul_b;

	logic signed [lpc_pkg::PROD_BITS-1:0]   prod_a_s2;
	logic signed [lpc_pkg::PROD_BITS-1:0]   prod_b_s2;
	logic                                   fade_s2;

	logic signed [lpc_pkg::MIX_BITS-1:0]    mix_s3;
	logic                                   fade_s3;

	logic signed [lpc_pkg::MIX_BITS-1:0]    mix_adj;
	logic signed [lpc_pkg::SHR_BITS-1:0]    mix_shr;
	logic signed [lpc_pkg::DATA_BITS-1:0]   mix_sat;

	logic signed [lpc_pkg::DATA_BITS-1:0]   out_sample_q;
	logic                                   out_fade_q;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= lpc_pkg::LOOP_START_RESET;
			end_addr_q   <= lpc_pkg::LOOP_END_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				lpc_pkg::REG_LOOP_START: start_addr_q <= pwdata[lpc_pkg::LOOP_START_BITS-1:0];
				lpc_pkg::REG_LOOP_END:   end_addr_q   <= pwdata[lpc_pkg::LOOP_END_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lpc_pkg::REG_LOOP_START: prdata = lpc_pkg::PDATA_BITS'(start_addr_q);
			lpc_pkg::REG_LOOP_END:   prdata = lpc_pkg::PDATA_BITS'(end_addr_q);
			default:                 prdata = '0;
		endcase
	end

	// pipeline flow control
	assign out_free = !out_valid_q || !out_stall;
	assign s3_free  = !valid_s3 || out_free;
	assign adv_s3   = valid_s3 && out_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign adv_s2   = valid_s2 && s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign adv_s1   = valid_s1 && s2_free;

	assign in_stall = !s1_free;
	assign in_acc   = in_valid && !in_stall;
	assign play_acc = in_acc && (mode == lpc_pkg::MODE_PLAY);
	assign load_acc = in_acc && (mode == lpc_pkg::MODE_LOAD);

	// fade region, head address, gains and next position
	assign fade_off = lpc_pkg::DIFF_BITS'(pos_q) - lpc_pkg::DIFF_BITS'(end_addr_q)
		+ lpc_pkg::DIFF_BITS'(lpc_pkg::FADE_LENGTH);
	assign in_fade  = !fade_off[lpc_pkg::DIFF_BITS-1];
	assign fade_idx = (fade_off > lpc_pkg::DIFF_BITS'(lpc_pkg::FADE_LENGTH - 1))
		? lpc_pkg::FADE_BITS'(lpc_pkg::FADE_LENGTH - 1)
		: fade_off[lpc_pkg::FADE_BITS-1:0];
	assign head_addr = lpc_pkg::ADDR_BITS'(lpc_pkg::SUM_BITS'(start_addr_q)
		+ lpc_pkg::SUM_BITS'(fade_idx));

	assign cos_gain = in_fade
		? lpc_pkg::GAIN_ROM[lpc_pkg::GAIN_IDX_BITS'(lpc_pkg::FADE_LENGTH)
			- lpc_pkg::GAIN_IDX_BITS'(fade_idx)]
		: lpc_pkg::UNITY_GAIN;
	assign sin_gain = lpc_pkg::GAIN_ROM[lpc_pkg::GAIN_IDX_BITS'(fade_idx)];

	assign pos_inc  = {1'b0, pos_q} + (lpc_pkg::ADDR_BITS + 1)'(1);
	assign pos_wrap = lpc_pkg::CMP_BITS'(pos_inc) >= lpc_pkg::CMP_BITS'(end_addr_q);
	assign pos_jump = lpc_pkg::ADDR_BITS'(lpc_pkg::SUM_BITS'(start_addr_q)
		+ lpc_pkg::SUM_BITS'(lpc_pkg::FADE_LENGTH));
	assign pos_next = pos_wrap ? pos_jump : pos_inc[lpc_pkg::ADDR_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (play_acc) begin
			pos_q <= pos_next;
		end
	end

	lpc_ram #(
		.WIDTH(lpc_pkg::DATA_BITS),
		.DEPTH(lpc_pkg::MEM_DEPTH)
	) u_store (
		.clk      (clk),
		.wr_en    (load_acc),
		.wr_addr  (load_address),
		.wr_data  (load_value),
		.rd_en    (play_acc),
		.rd_addr_a(pos_q),
		.rd_addr_b(head_addr),
		.rd_data_a(ram_a),
		.rd_data_b(ram_b)
	);

	// stage 1: store read data plus gains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= play_acc || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (play_acc) begin
			fade_s1 <= in_fade;
			cos_s1  <= cos_gain;
			sin_s1  <= sin_gain;
		end
	end

	// stage 2: gain products
	assign samp_a = $signed(ram_a);
	assign samp_b = $signed(ram_b);
	assign cos_sg = $signed({1'b0, cos_s1});
	assign sin_sg = $signed({1'b0, sin_s1});
	assign mul_a  = lpc_pkg::PROD_BITS'(samp_a) * lpc_pkg::PROD_BITS'(cos_sg);
	assign mul_b  = lpc_pkg::PROD_BITS'(samp_b) * lpc_pkg::PROD_BITS'(sin_sg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv_s1 || (valid_s2 && !adv_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			prod_a_s2 <= mul_a;
			prod_b_s2 <= fade_s1 ? mul_b : '0;
			fade_s2   <= fade_s1;
		end
	end

	// stage 3: mix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= adv_s2 || (valid_s3 && !adv_s2 && !adv_s3) || (valid_s3 && adv_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			mix_s3  <= lpc_pkg::MIX_BITS'(prod_a_s2) + lpc_pkg::MIX_BITS'(prod_b_s2);
			fade_s3 <= fade_s2;
		end
	end

	// scale toward zero and saturate
	assign mix_adj = mix_s3[lpc_pkg::MIX_BITS-1]
		? mix_s3 + lpc_pkg::MIX_BITS'((1 << lpc_pkg::GAIN_FRAC_BITS) - 1)
		: mix_s3;
	assign mix_shr = lpc_pkg::SHR_BITS'(mix_adj >>> lpc_pkg::GAIN_FRAC_BITS);

	always_comb begin
		if (mix_shr > lpc_pkg::SHR_BITS'(signed'(32'sh7FFF_FFFF))) begin
			mix_sat = 32'sh7FFF_FFFF;
		end else if (mix_shr < lpc_pkg::SHR_BITS'(signed'(32'sh8000_0000))) begin
			mix_sat = 32'sh8000_0000;
		end else begin
			mix_sat = mix_shr[lpc_pkg::DATA_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv_s3 || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			out_sample_q <= mix_sat;
			out_fade_q   <= fade_s3;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_sample   = out_sample_q;
	assign in_crossfade = out_fade_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with stage 1 empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> $stable(pos_q))
		else $error("play position moved on a load transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		play_acc |=> valid_s1)
		else $error("accepted play transfer lost at stage 1");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s3) |=> !out_valid)
		else $error("result repeated after transfer");

endmodule
`default_nettype wire
